### src/hsv2rgb_pkg.sv
// Shared constants, types and the hue fraction function for the HSV to RGB converter.
`default_nettype none
package hsv2rgb_pkg;

  localparam int unsigned HueWidth  = 16;
  localparam int unsigned QWidth    = 9;   // Q1.8 operands, 256 is 1.0
  localparam int unsigned ByteWidth = 8;
  localparam int unsigned SecWidth  = 3;
  localparam int unsigned FracWidth = 8;
  localparam int unsigned HueModW   = 9;   // hue after reduction, 0..359
  localparam int unsigned RemWidth  = 6;   // degrees within a sector, 0..59
  localparam int unsigned QuotWidth = 7;   // hue / 360 for a 16-bit magnitude

  localparam int unsigned FullTurn  = 360;
  localparam int unsigned SectorDeg = 60;

  // ceil(2^24 / 360): exact floor(h / 360) for h < 2^16, corrected once anyway
  localparam logic [15:0] HueRecip  = 16'd46604;
  localparam int unsigned HueShift  = 24;

  // 256/60 scaled by 2^9 and rounded up; the excess stays below 1/15 for 0..59
  localparam int unsigned FracProdW = RemWidth + 12;
  localparam logic [11:0] FracRecip = 12'd2185;
  localparam int unsigned FracShift = 9;

  localparam logic [QWidth-1:0] OneQ8 = 9'd256;

  // sector codes, red at zero degrees
  localparam logic [SecWidth-1:0] SEC_R_TO_Y = 3'd0;
  localparam logic [SecWidth-1:0] SEC_Y_TO_G = 3'd1;
  localparam logic [SecWidth-1:0] SEC_G_TO_C = 3'd2;
  localparam logic [SecWidth-1:0] SEC_C_TO_B = 3'd3;
  localparam logic [SecWidth-1:0] SEC_B_TO_M = 3'd4;
  localparam logic [SecWidth-1:0] SEC_M_TO_R = 3'd5;

  typedef struct packed {
    logic [SecWidth-1:0]  sector;
    logic [FracWidth-1:0] frac;
  } hue_split_t;

  // fraction through the sector in Q0.8, truncated: rem*256/60 by reciprocal
  function automatic logic [FracWidth-1:0] frac_of(input logic [RemWidth-1:0] rem);
    logic [FracProdW-1:0] prod;
    prod = FracProdW'(rem) * FracProdW'(FracRecip);
    return prod[FracShift +: FracWidth];
  endfunction

endpackage
`default_nettype wire

### src/hsv2rgb_hue.sv
// Four-stage hue path: magnitude, reduction modulo 360, sector and fraction.
`default_nettype none
module hsv2rgb_hue
  import hsv2rgb_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                en_i,
  input  wire logic [HueWidth-1:0] hue_degrees_i,
  output hue_split_t               split_o
);

  logic [HueWidth-1:0]  abs_d, abs_q;
  logic [HueWidth-1:0]  h2_q;
  logic [QuotWidth-1:0] quot_d, quot_q;
  logic [HueModW-1:0]   h3_d, h3_q;
  hue_split_t           split_d, split_q;

  logic [31:0]          recip_prod;
  logic [15:0]          turn_prod;
  logic [15:0]          rem_wide;
  logic [9:0]           rem_red;
  logic [HueModW-1:0]   base;
  logic [HueModW-1:0]   in_sec;

  // stage 1: magnitude; -32768 maps to 32768, which still fits unsigned
  assign abs_d = hue_degrees_i[HueWidth-1] ? (~hue_degrees_i + 16'd1) : hue_degrees_i;

  // stage 2: quotient estimate by reciprocal
  assign recip_prod = abs_q * HueRecip;
  assign quot_d     = recip_prod[HueShift +: QuotWidth];

  // stage 3: remainder with one correction step
  assign turn_prod = 16'(quot_q * 16'(FullTurn));
  assign rem_wide  = h2_q - turn_prod;
  assign rem_red   = rem_wide[9:0];
  assign h3_d      = (rem_red >= 10'(FullTurn)) ? HueModW'(rem_red - 10'(FullTurn))
                                                : rem_red[HueModW-1:0];

  // stage 4: sector by compare, fraction by reciprocal
  always_comb begin
    if (h3_q >= HueModW'(SectorDeg * 5)) begin
      split_d.sector = SEC_M_TO_R;
      base           = HueModW'(SectorDeg * 5);
    end else if (h3_q >= HueModW'(SectorDeg * 4)) begin
      split_d.sector = SEC_B_TO_M;
      base           = HueModW'(SectorDeg * 4);
    end else if (h3_q >= HueModW'(SectorDeg * 3)) begin
      split_d.sector = SEC_C_TO_B;
      base           = HueModW'(SectorDeg * 3);
    end else if (h3_q >= HueModW'(SectorDeg * 2)) begin
      split_d.sector = SEC_G_TO_C;
      base           = HueModW'(SectorDeg * 2);
    end else if (h3_q >= HueModW'(SectorDeg)) begin
      split_d.sector = SEC_Y_TO_G;
      base           = HueModW'(SectorDeg);
    end else begin
      split_d.sector = SEC_R_TO_Y;
      base           = '0;
    end
    in_sec       = h3_q - base;
    split_d.frac = frac_of(in_sec[RemWidth-1:0]);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      abs_q   <= abs_d;
      h2_q    <= abs_q;
      quot_q  <= quot_d;
      h3_q    <= h3_d;
      split_q <= split_d;
    end
  end

  assign split_o = split_q;

endmodule
`default_nettype wire

### src/hsv_to_rgb_converter.sv
// Top level: pipelined HSV to RGB converter with valid/ready on both sides.
//
//   channel  direction  handshake                 payload
//   in       sink       in_valid_i / in_ready_o   hue_degrees_i, saturation_i, brightness_i
//   out      source     out_valid_o / out_ready_i red_o, green_o, blue_o, packed_rgb_o
//
// Seven register stages; one item per clock while the output item is not held.
// The hue reduction and the two rows of 9x9 products set the stage split.
// Reset clears the valid bits only; data registers carry no reset.
// When the output item is held, the whole pipeline holds and in_ready_o drops;
// nothing is lost or repeated.
`default_nettype none
module hsv_to_rgb_converter
  import hsv2rgb_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output wire logic                 in_ready_o,
  input  wire logic [HueWidth-1:0]  hue_degrees_i,
  input  wire logic [QWidth-1:0]    saturation_i,
  input  wire logic [QWidth-1:0]    brightness_i,
  output wire logic                 out_valid_o,
  input  wire logic                 out_ready_i,
  output wire logic [ByteWidth-1:0] red_o,
  output wire logic [ByteWidth-1:0] green_o,
  output wire logic [ByteWidth-1:0] blue_o,
  output wire logic [23:0]          packed_rgb_o
);

  localparam int unsigned Depth = 7;

  logic              en;
  logic [Depth:1]    vld_d, vld_q;
  hue_split_t        split;

  // saturation travels alongside the hue path for stages 1..4, value for stages 1..6
  logic [QWidth-1:0] s_d, v_d;
  logic [QWidth-1:0] s_q [1:4];
  logic [QWidth-1:0] v_q [1:6];
  hue_split_t        split_q [5:6];

  logic [17:0]       fs_prod, nfs_prod, p_prod;
  logic [QWidth-1:0] fs_d, fs_q, nfs_d, nfs_q, p5_d, p5_q, p6_q;
  logic [17:0]       q_prod, t_prod;
  logic [QWidth-1:0] q_d, q_q, t_d, t_q;
  logic [QWidth-1:0] r_sel, g_sel, b_sel;
  logic [ByteWidth-1:0] r_d, r_q, g_d, g_q, b_d, b_q;

  function automatic logic [ByteWidth-1:0] chan_byte(input logic [QWidth-1:0] x);
    logic [16:0] scaled;
    scaled = {x, 8'd0} - 17'(x);   // x*255, at most 65280
    return scaled[15:8];
  endfunction

  assign en         = !vld_q[Depth] || out_ready_i;
  assign in_ready_o = en;
  assign vld_d      = {vld_q[Depth-1:1], in_valid_i};

  assign s_d = (saturation_i > OneQ8) ? OneQ8 : saturation_i;
  assign v_d = (brightness_i > OneQ8) ? OneQ8 : brightness_i;

  hsv2rgb_hue u_hue (
    .clk_i         (clk_i),
    .en_i          (en),
    .hue_degrees_i (hue_degrees_i),
    .split_o       (split)
  );

  // stage 5: f*s, (1-f)*s and p
  assign fs_prod  = 18'(split.frac) * 18'(s_q[4]);
  assign nfs_prod = 18'(OneQ8 - 9'(split.frac)) * 18'(s_q[4]);
  assign p_prod   = 18'(v_q[4]) * 18'(OneQ8 - s_q[4]);
  assign fs_d     = fs_prod[16:8];
  assign nfs_d    = nfs_prod[16:8];
  assign p5_d     = p_prod[16:8];

  // stage 6: q and t
  assign q_prod = 18'(v_q[5]) * 18'(OneQ8 - fs_q);
  assign t_prod = 18'(v_q[5]) * 18'(OneQ8 - nfs_q);
  assign q_d    = q_prod[16:8];
  assign t_d    = t_prod[16:8];

  // stage 7: channel order by sector, then scale to a byte
  always_comb begin
    case (split_q[6].sector)
      SEC_R_TO_Y: begin r_sel = v_q[6]; g_sel = t_q;    b_sel = p6_q;   end
      SEC_Y_TO_G: begin r_sel = q_q;    g_sel = v_q[6]; b_sel = p6_q;   end
      SEC_G_TO_C: begin r_sel = p6_q;   g_sel = v_q[6]; b_sel = t_q;    end
      SEC_C_TO_B: begin r_sel = p6_q;   g_sel = q_q;    b_sel = v_q[6]; end
      SEC_B_TO_M: begin r_sel = t_q;    g_sel = p6_q;   b_sel = v_q[6]; end
      default:    begin r_sel = v_q[6]; g_sel = p6_q;   b_sel = q_q;    end
    endcase
    r_d = chan_byte(r_sel);
    g_d = chan_byte(g_sel);
    b_d = chan_byte(b_sel);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s_q[1]     <= s_d;
      s_q[2]     <= s_q[1];
      s_q[3]     <= s_q[2];
      s_q[4]     <= s_q[3];
      v_q[1]     <= v_d;
      v_q[2]     <= v_q[1];
      v_q[3]     <= v_q[2];
      v_q[4]     <= v_q[3];
      v_q[5]     <= v_q[4];
      v_q[6]     <= v_q[5];
      split_q[5] <= split;
      split_q[6] <= split_q[5];
      fs_q       <= fs_d;
      nfs_q      <= nfs_d;
      p5_q       <= p5_d;
      p6_q       <= p5_q;
      q_q        <= q_d;
      t_q        <= t_d;
      r_q        <= r_d;
      g_q        <= g_d;
      b_q        <= b_d;
    end
  end

  assign out_valid_o  = vld_q[Depth];
  assign red_o        = r_q;
  assign green_o      = g_q;
  assign blue_o       = b_q;
  assign packed_rgb_o = {r_q, g_q, b_q};

  // a held result must hold the intake too
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |-> !in_ready_o)
    else $error("intake open while result held");

  // an accepted item enters the first stage
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> vld_q[1])
    else $error("accepted item not in stage one");

  // a stall freezes every valid bit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |=> $stable(vld_q))
    else $error("pipeline moved during stall");

  // p, q and t never exceed the value they scale
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[6] |-> (p6_q <= v_q[6]) && (q_q <= v_q[6]) && (t_q <= v_q[6]))
    else $error("scaled term above value");

endmodule
`default_nettype wire

### sim/hsv_to_rgb_checker.sv
// Checker for the HSV to RGB converter: predicts each colour and compares it.
module hsv_to_rgb_checker
  import hsv2rgb_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 in_ready_i,
  input  logic [HueWidth-1:0]  hue_degrees_i,
  input  logic [QWidth-1:0]    saturation_i,
  input  logic [QWidth-1:0]    brightness_i,
  input  logic                 out_valid_i,
  input  logic                 out_ready_i,
  input  logic [ByteWidth-1:0] red_i,
  input  logic [ByteWidth-1:0] green_i,
  input  logic [ByteWidth-1:0] blue_i,
  input  logic [23:0]          packed_rgb_i,
  output int                   errors_o,
  output int                   pending_o,
  output int                   checked_o
);

  typedef struct packed {
    logic [ByteWidth-1:0] red;
    logic [ByteWidth-1:0] green;
    logic [ByteWidth-1:0] blue;
    logic [23:0]          packed_rgb;
  } pixel_t;

  pixel_t owed_px [$];
  int     mismatches = 0;
  int     compared   = 0;

  // scale a Q1.8 level to a byte, truncating, capped at 255
  function automatic logic [ByteWidth-1:0] level_to_byte(input int unsigned x);
    int unsigned b;
    b = (x * 255) >> 8;
    return (b > 255) ? 8'd255 : b[7:0];
  endfunction

  function automatic pixel_t rgb_of_hsv(input logic [HueWidth-1:0] hue,
                                        input logic [QWidth-1:0]   sat,
                                        input logic [QWidth-1:0]   val);
    int unsigned mag, deg, sec, f, s, v, p, q, t, r, g, b;
    pixel_t      px;
    // magnitude of the two's complement hue; 0x8000 gives 32768
    mag = hue[HueWidth-1] ? (32'h10000 - 32'(hue)) : 32'(hue);
    deg = mag % FullTurn;
    s   = (sat > OneQ8) ? 32'(OneQ8) : 32'(sat);
    v   = (val > OneQ8) ? 32'(OneQ8) : 32'(val);
    sec = deg / SectorDeg;
    f   = ((deg % SectorDeg) * 256) / SectorDeg;
    p   = (v * (256 - s)) >> 8;
    q   = (v * (256 - ((f * s) >> 8))) >> 8;
    t   = (v * (256 - (((256 - f) * s) >> 8))) >> 8;
    case (sec[SecWidth-1:0])
      SEC_R_TO_Y: begin r = v; g = t; b = p; end
      SEC_Y_TO_G: begin r = q; g = v; b = p; end
      SEC_G_TO_C: begin r = p; g = v; b = t; end
      SEC_C_TO_B: begin r = p; g = q; b = v; end
      SEC_B_TO_M: begin r = t; g = p; b = v; end
      default: begin r = v; g = p; b = q; end
    endcase
    px.red        = level_to_byte(r);
    px.green      = level_to_byte(g);
    px.blue       = level_to_byte(b);
    px.packed_rgb = {px.red, px.green, px.blue};
    return px;
  endfunction

  task automatic check_field(input string what, input logic [23:0] want,
                             input logic [23:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
    end
  endtask

  always @(posedge clk_i) begin
    pixel_t want;
    if (rst_ni) begin
      if (in_valid_i && in_ready_i)
        owed_px.push_back(rgb_of_hsv(hue_degrees_i, saturation_i, brightness_i));
      if (out_valid_i && out_ready_i) begin
        if (owed_px.size() == 0) begin
          mismatches++;
          $display("%0t: colour %06h arrived with none owed", $time, packed_rgb_i);
        end else begin
          want = owed_px.pop_front();
          compared++;
          check_field("red", 24'(want.red), 24'(red_i));
          check_field("green", 24'(want.green), 24'(green_i));
          check_field("blue", 24'(want.blue), 24'(blue_i));
          check_field("packed_rgb", want.packed_rgb, packed_rgb_i);
        end
      end
    end
    pending_o = owed_px.size();
    errors_o  = mismatches;
    checked_o = compared;
  end

endmodule

### sim/hsv_to_rgb_converter_tb.sv
// Testbench top for the HSV to RGB converter: stimulus, stalls and verdict.
module hsv_to_rgb_converter_tb;
  import hsv2rgb_pkg::*;

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_ready;
  logic [HueWidth-1:0]  hue;
  logic [QWidth-1:0]    sat;
  logic [QWidth-1:0]    val;
  logic                 out_valid;
  logic                 out_ready;
  logic [ByteWidth-1:0] red;
  logic [ByteWidth-1:0] green;
  logic [ByteWidth-1:0] blue;
  logic [23:0]          packed_rgb;

  int mismatches;
  int pending;
  int checked;
  int sent          = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int holds_asked   = 0;

  hsv_to_rgb_converter dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_ready_o    (in_ready),
    .hue_degrees_i (hue),
    .saturation_i  (sat),
    .brightness_i  (val),
    .out_valid_o   (out_valid),
    .out_ready_i   (out_ready),
    .red_o         (red),
    .green_o       (green),
    .blue_o        (blue),
    .packed_rgb_o  (packed_rgb)
  );

  hsv_to_rgb_checker colour_check (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_ready_i    (in_ready),
    .hue_degrees_i (hue),
    .saturation_i  (sat),
    .brightness_i  (val),
    .out_valid_i   (out_valid),
    .out_ready_i   (out_ready),
    .red_i         (red),
    .green_i       (green),
    .blue_i        (blue),
    .packed_rgb_i  (packed_rgb),
    .errors_o      (mismatches),
    .pending_o     (pending),
    .checked_o     (checked)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #3_000_000;
    $display("status: fail");
    $finish;
  end

  // mostly in-range levels, some above 1.0 to hit the clamp, some corners
  function automatic logic [QWidth-1:0] pick_level();
    case ($urandom_range(9))
      7, 8: return QWidth'($urandom_range(511, 257));
      9: begin
        case ($urandom_range(3))
          0: return 9'd0;
          1: return 9'd1;
          2: return 9'd255;
          default: return OneQ8;
        endcase
      end
      default: return QWidth'($urandom_range(256));
    endcase
  endfunction

  // returns at the edge where the item was taken, valid still high
  task automatic push_pixel(input logic [HueWidth-1:0] h, input logic [QWidth-1:0] s,
                            input logic [QWidth-1:0] v);
    logic took;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    hue      <= h;
    sat      <= s;
    val      <= v;
    do begin
      @(negedge clk);
      took = in_ready;
      @(posedge clk);
    end while (!took);
    sent++;
  endtask

  // sender stops until every owed colour has come out
  task automatic drain_pipe();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    @(posedge clk);
  endtask

  // receiver: random stalls plus long hold-offs on request
  initial begin
    int hold_left;
    int holds_done;
    hold_left  = 0;
    holds_done = 0;
    out_ready  = 1'b0;
    forever begin
      @(posedge clk);
      if (holds_asked != holds_done) begin
        holds_done = holds_asked;
        hold_left  = 40 + $urandom_range(20);
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  initial begin
    int                  hval;
    logic [HueWidth-1:0] h;
    in_valid = 1'b0;
    hue      = '0;
    sat      = '0;
    val      = '0;
    rst_n    = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // primaries and secondaries, each sector, wrap and sign of the hue, clamps
    push_pixel(16'd0, 9'd256, 9'd256);
    push_pixel(16'd60, 9'd256, 9'd256);
    push_pixel(16'd120, 9'd256, 9'd256);
    push_pixel(16'd180, 9'd256, 9'd256);
    push_pixel(16'd240, 9'd256, 9'd256);
    push_pixel(16'd300, 9'd256, 9'd256);
    push_pixel(16'd359, 9'd256, 9'd256);
    push_pixel(16'd360, 9'd256, 9'd256);
    push_pixel(16'd720, 9'd200, 9'd180);
    push_pixel(16'(-32768), 9'd256, 9'd256);
    push_pixel(16'd32767, 9'd256, 9'd256);
    push_pixel(16'(-1), 9'd256, 9'd256);
    push_pixel(16'(-360), 9'd128, 9'd256);
    push_pixel(16'(-32767), 9'd100, 9'd200);
    push_pixel(16'd0, 9'd0, 9'd256);
    push_pixel(16'd90, 9'd256, 9'd0);
    push_pixel(16'd200, 9'd511, 9'd511);
    push_pixel(16'd30, 9'd300, 9'd128);
    push_pixel(16'd90, 9'd128, 9'd400);
    push_pixel(16'd45, 9'd257, 9'd256);
    push_pixel(16'd150, 9'd0, 9'd0);
    push_pixel(16'd270, 9'd128, 9'd128);
    push_pixel(16'd330, 9'd255, 9'd255);
    push_pixel(16'(-180), 9'd1, 9'd1);
    push_pixel(16'd15, 9'd256, 9'd255);
    drain_pipe();

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin send_idle_pct = 9;  recv_idle_pct <= 61; end
        1: begin send_idle_pct = 61; recv_idle_pct <= 9;  end
        default: begin send_idle_pct = 0; recv_idle_pct <= 0; end
      endcase
      for (int i = 0; i < 560; i++) begin
        if (i == 150) holds_asked <= holds_asked + 1;
        if (i == 400) drain_pipe();
        case ($urandom_range(9))
          5, 6, 7: h = HueWidth'($urandom_range(359));
          8, 9: begin
            // near a whole turn, either sign
            hval = $urandom_range(91) * 360 + $urandom_range(2) - 1;
            if (hval < 0) hval = 0;
            if ($urandom_range(1)) hval = -hval;
            h = HueWidth'(hval);
          end
          default: h = HueWidth'($urandom);
        endcase
        push_pixel(h, pick_level(), pick_level());
      end
    end

    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    $display("covered %0d pixels: all six sectors, signed and wrapped hues, clamped levels",
             sent);
    $display("%0d colours compared under mixed stalls and long output hold-offs", checked);
    if (mismatches == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule
